// ===== hdl/sorted_top_n_table_macros.svh =====
// Assertion macros shared by the sorted score table RTL.
// Included by the modules that carry concurrent assertions.
`ifndef SORTED_TOP_N_TABLE_MACROS_SVH
`define SORTED_TOP_N_TABLE_MACROS_SVH

// pre implies post in the same cycle
`define STNT_ASSERT_IMPLY(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// pre implies post in the next cycle
`define STNT_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/stnt_pkg.sv =====
// Types and constants of the sorted score table.
// No dependencies; imported by every module of the block but stnt_ram.
`default_nettype none

package stnt_pkg;

	localparam int POINTS_W = 31;
	localparam int ZONE_W   = 16;
	localparam int CHAIN_W  = 16;
	localparam int LABEL_W  = 64;
	localparam int INDEX_W  = 8;
	localparam int RANK_W   = 7;
	localparam int COUNT_W  = 7;

	// fallback name, first character in the low byte
	localparam logic [LABEL_W-1:0] DEFAULT_NAME = 64'h0000_0000_4E4F_5841;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_WRITE,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [LABEL_W-1:0]  label;
		logic [CHAIN_W-1:0]  chain;
		logic [ZONE_W-1:0]   zone;
		logic [POINTS_W-1:0] points;
	} rec_t;

	typedef struct packed {
		rec_t               entry;
		logic               entry_valid;
		logic [COUNT_W-1:0] entry_count;
		logic               inserted;
		logic signed [RANK_W-1:0] rank;
	} res_t;

	typedef struct packed {
		logic load_in;
		logic scan_start;
		logic scan_step;
		logic place_load;
		logic grow;
		logic shift;
		logic write_new;
		logic rd_entry;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic pts_zero;
		logic count_zero;
		logic prev_in;
		logic lt;
		logic place_full;
		logic idx_gt_place;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_top_n_table.sv =====
// Sorted score table, top level: stream ports, sequencer and datapath.
// Depends on stnt_pkg, stnt_ctrl, stnt_dp (with stnt_ram).
//
// Usage:
//   Requests arrive on the s_axis channel, one item each; the op code in
//   s_axis_tuser selects insert, rank query or entry read. Each request gives
//   exactly one result item on the m_axis channel.
//   The table keeps up to TABLE_DEPTH records in descending order of points,
//   held in a single record RAM; it is empty after arst_n.
//   Steps from accept to result valid:
//     read:               one RAM read of the clamped entry
//     rank query:         scan to the place found, one RAM read per compared entry
//     insert:             scan, then shift the entries from the place on down,
//                         one shift per cycle; a refused insert does not shift
//     zero points, op 3:  no RAM access, straight to the result
//   One request is in work at a time; s_axis_tready is high only while idle,
//   starting the cycle after the result is loaded. A stalled receiver holds the
//   result register; the next request is accepted and worked on meanwhile,
//   waiting only at its own result until the register is taken.
`default_nettype none

module sorted_top_n_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int LABEL_CHARS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// new_points, new_zone, new_chain, new_label, read_index, zero pad
	input  wire logic [135:0] s_axis_tdata,
	// op
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// rank, entry_count, entry_points, entry_zone, entry_chain, entry_label, zero pad
	output logic [143:0]      m_axis_tdata,
	// inserted, entry_valid
	output logic [1:0]        m_axis_tuser
);

	import stnt_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res;

	stnt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	stnt_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.LABEL_CHARS(LABEL_CHARS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_op    (op_t'(s_axis_tuser)),
		.in_rec   (rec_t'(s_axis_tdata[126:0])),
		.in_index ($signed(s_axis_tdata[134:127])),
		.res      (res),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready)
	);

	assign m_axis_tdata = {3'b000, res.entry, res.entry_count, res.rank};
	assign m_axis_tuser = {res.entry_valid, res.inserted};

endmodule

`default_nettype wire

// ===== hdl/stnt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module stnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/stnt_ctrl.sv =====
// Sequencer of the sorted score table: scan, shift, write and read steps.
// Depends on stnt_pkg; drives the datapath through cmd_t, watches sts_t.
`default_nettype none

module stnt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire stnt_pkg::sts_t sts,
	output stnt_pkg::cmd_t      cmd
);

	import stnt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				case (sts.op)
					OP_INSERT, OP_QUERY: state_d = sts.pts_zero ? ST_DONE : ST_SCAN;
					OP_READ:             state_d = sts.count_zero ? ST_DONE : ST_READ;
					default:             state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				if (!sts.prev_in || sts.lt) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.place_full || sts.op == OP_QUERY) state_d = ST_DONE;
				else state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (!sts.idx_gt_place) state_d = ST_WRITE;
			end
			ST_WRITE: state_d = ST_DONE;
			ST_READ:  state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_START: begin
				case (sts.op)
					OP_INSERT, OP_QUERY: cmd.scan_start = !sts.pts_zero;
					OP_READ:             cmd.rd_entry   = !sts.count_zero;
					default:             ;
				endcase
			end
			ST_SCAN: begin
				if (!sts.prev_in || sts.lt) cmd.place_load = 1'b1;
				else cmd.scan_step = 1'b1;
			end
			ST_DECIDE: begin
				cmd.grow = !sts.place_full && sts.op == OP_INSERT;
			end
			ST_SHIFT: cmd.shift     = 1'b1;
			ST_WRITE: cmd.write_new = 1'b1;
			ST_READ:  ;
			ST_DONE:  cmd.out_load  = sts.out_free;
			default:  ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/stnt_dp.sv =====
// Datapath of the sorted score table: record RAM, count, scan/shift index,
// result register. Depends on stnt_pkg, stnt_ram and the macro header.
`default_nettype none
`include "sorted_top_n_table_macros.svh"

module stnt_dp #(
	parameter int TABLE_DEPTH = 16,
	parameter int LABEL_CHARS = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire stnt_pkg::cmd_t                        cmd,
	output stnt_pkg::sts_t                             sts,
	input  wire stnt_pkg::op_t                         in_op,
	input  wire stnt_pkg::rec_t                        in_rec,
	input  wire logic signed [stnt_pkg::INDEX_W-1:0]   in_index,
	output stnt_pkg::res_t                             res,
	output logic                                       out_valid,
	input  wire logic                                  out_ready
);

	import stnt_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH + 2);
	localparam int RW = $bits(rec_t);

	op_t                       op_q;
	rec_t                      new_q;
	logic signed [INDEX_W-1:0] ridx_q;
	logic [CW-1:0]             count_q;
	logic [IW-1:0]             idx_q;
	logic [IW-1:0]             place_q;
	logic                      wpend_q;
	logic                      out_valid_q;
	res_t                      res_q;
	res_t                      res_d;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;
	rec_t          rd_rec;

	logic         count_full;
	logic         idx_gt_place;
	logic         out_free;
	logic         rej;
	logic [7:0]   cnt8;
	logic [7:0]   clamp;

	function automatic logic [LABEL_W-1:0] clean_label(input logic [LABEL_W-1:0] raw);
		logic [LABEL_W-1:0] kept;
		logic [LABEL_W-1:0] dflt;
		logic               stop;
		kept = '0;
		dflt = DEFAULT_NAME;
		stop = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (b < LABEL_CHARS && !stop) begin
				if (raw[8*b +: 8] == 8'h00) stop = 1'b1;
				else kept[8*b +: 8] = raw[8*b +: 8];
			end
			if (b >= LABEL_CHARS) dflt[8*b +: 8] = 8'h00;
		end
		return (kept == '0) ? dflt : kept;
	endfunction

	stnt_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_rec       = rec_t'(ram_rdata);
	assign count_full   = count_q == CW'(TABLE_DEPTH);
	assign idx_gt_place = idx_q > place_q;
	assign out_free     = !out_valid_q || out_ready;

	// clamp the signed read index into the filled range
	always_comb begin
		cnt8 = 8'(count_q);
		if (ridx_q[INDEX_W-1]) clamp = 8'd0;
		else if ($unsigned(ridx_q) >= cnt8) clamp = cnt8 - 8'd1;
		else clamp = $unsigned(ridx_q);
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (cmd.scan_start) begin
			ram_re = 1'b1;
		end else if (cmd.scan_step) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(idx_q);
		end else if (cmd.shift && idx_gt_place) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(idx_q - IW'(1));
		end else if (cmd.rd_entry) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(clamp);
		end
	end

	// shift moves the entry read last cycle one place down
	always_comb begin
		ram_we    = (cmd.shift && wpend_q) || cmd.write_new;
		ram_waddr = cmd.shift ? AW'(idx_q + IW'(1)) : AW'(place_q);
		ram_wdata = cmd.shift ? ram_rdata : RW'(new_q);
	end

	assign sts.op           = op_q;
	assign sts.pts_zero     = new_q.points == '0;
	assign sts.count_zero   = count_q == '0;
	assign sts.prev_in      = (idx_q - IW'(1)) < IW'(count_q);
	assign sts.lt           = rd_rec.points < new_q.points;
	assign sts.place_full   = place_q == IW'(TABLE_DEPTH);
	assign sts.idx_gt_place = idx_gt_place;
	assign sts.out_free     = out_free;

	assign rej = sts.pts_zero || sts.place_full;

	always_comb begin
		res_d             = '0;
		res_d.entry_count = COUNT_W'(count_q);
		case (op_q)
			OP_INSERT, OP_QUERY: begin
				res_d.rank     = rej ? -7'sd1 : $signed(RANK_W'(place_q));
				res_d.inserted = (op_q == OP_INSERT) && !rej;
			end
			OP_READ: begin
				res_d.entry_valid = !sts.count_zero;
				if (!sts.count_zero) res_d.entry = rd_rec;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			place_q     <= '0;
			wpend_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_start) idx_q <= IW'(1);
			else if (cmd.scan_step) idx_q <= idx_q + IW'(1);
			else if (cmd.grow) idx_q <= count_full ? IW'(TABLE_DEPTH - 1) : IW'(count_q);
			else if (cmd.shift && idx_gt_place) idx_q <= idx_q - IW'(1);

			if (cmd.place_load) place_q <= idx_q - IW'(1);

			if (cmd.grow) begin
				if (!count_full) count_q <= count_q + CW'(1);
				wpend_q <= 1'b0;
			end else if (cmd.shift && idx_gt_place) begin
				wpend_q <= 1'b1;
			end

			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q         <= in_op;
			new_q.points <= in_rec.points;
			new_q.zone   <= in_rec.zone;
			new_q.chain  <= in_rec.chain;
			new_q.label  <= clean_label(in_rec.label);
			ridx_q       <= in_index;
		end
		if (cmd.out_load) res_q <= res_d;
	end

	assign res       = res_q;
	assign out_valid = out_valid_q;

	`STNT_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH), "count past depth")
	`STNT_ASSERT_IMPLY(a_rw_clash, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr, "RAM read and write hit one entry")
	`STNT_ASSERT_NEXT(a_count_steady, clk, arst_n, !cmd.grow, $stable(count_q), "count moved without an insert")
	`STNT_ASSERT_IMPLY(a_load_free, clk, arst_n, cmd.out_load, out_free, "result overwritten before taken")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for sorted_top_n_table: inserts, rank queries and reads
// go through the stream ports, and each result is checked against a local table model.
// Depends on stnt_pkg and the sorted_top_n_table RTL.
`default_nettype none

module testbench;
	import stnt_pkg::*;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [POINTS_W-1:0] points;
		logic [ZONE_W-1:0]   zone;
		logic [CHAIN_W-1:0]  chain;
		logic [LABEL_W-1:0]  label;
		logic signed [INDEX_W-1:0] idx;
	} request_t;

	typedef struct packed {
		logic signed [RANK_W-1:0] rank;
		logic                     inserted;
		logic [COUNT_W-1:0]       count;
		logic                     valid;
		rec_t                     entry;
	} score_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	rec_t          score_table[DEPTH];
	int            filled = 0;
	score_result_t pending_results[$];

	bit idle_on = 1'b1;
	bit stall_on = 1'b1;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	int results_checked = 0;
	int n_insert = 0, n_query = 0, n_read = 0, n_other = 0, n_stored = 0;

	sorted_top_n_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [LABEL_W-1:0] tidy_name(logic [LABEL_W-1:0] raw);
		logic [LABEL_W-1:0] kept;
		logic               stop;
		kept = '0;
		stop = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (raw[8*b +: 8] == 8'd0)
				stop = 1'b1;
			if (!stop)
				kept[8*b +: 8] = raw[8*b +: 8];
		end
		if (kept == '0)
			kept = DEFAULT_NAME;
		return kept;
	endfunction

	// updates the table model and returns the result the block must give
	function automatic score_result_t apply_request(request_t r);
		score_result_t res;
		int            place;
		int            pos;
		res = '0;
		if (r.op == OP_INSERT || r.op == OP_QUERY) begin
			if (r.points == '0) begin
				place = -1;
			end else begin
				place = 0;
				while (place < filled && score_table[place].points >= r.points)
					place++;
				if (place >= DEPTH)
					place = -1;
			end
			res.rank = place[RANK_W-1:0];
			if (r.op == OP_INSERT && place >= 0) begin
				if (filled < DEPTH)
					filled++;
				for (int k = filled - 1; k > place; k--)
					score_table[k] = score_table[k-1];
				score_table[place].points = r.points;
				score_table[place].zone = r.zone;
				score_table[place].chain = r.chain;
				score_table[place].label = tidy_name(r.label);
				res.inserted = 1'b1;
			end
		end else if (r.op == OP_READ && filled > 0) begin
			pos = $signed(r.idx);
			if (pos < 0)
				pos = 0;
			if (pos >= filled)
				pos = filled - 1;
			res.valid = 1'b1;
			res.entry = score_table[pos];
		end
		res.count = filled[COUNT_W-1:0];
		return res;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       sel;
		r.zone = 16'($urandom_range(16'hFFFF));
		r.chain = 16'($urandom_range(16'hFFFF));
		sel = $urandom_range(99);
		if (sel < 40)
			r.op = OP_INSERT;
		else if (sel < 60)
			r.op = OP_QUERY;
		else if (sel < 92)
			r.op = OP_READ;
		else
			r.op = OP_UNUSED;
		sel = $urandom_range(9);
		if (sel == 0)
			r.points = '0;
		else if (sel <= 2)
			r.points = 31'($urandom());
		else if (sel <= 4 && filled > 0)
			r.points = score_table[$urandom_range(filled - 1)].points;
		else
			r.points = 31'($urandom_range(60, 1));
		for (int b = 0; b < 8; b++)
			r.label[8*b +: 8] = ($urandom_range(99) < 15) ? 8'd0 : 8'($urandom_range(255, 1));
		if ($urandom_range(9) == 0)
			r.label[7:0] = 8'd0;
		if ($urandom_range(1))
			r.idx = 8'($urandom_range(255));
		else
			r.idx = 8'($urandom_range(filled + 1) - 1);
		return r;
	endfunction

	task automatic send_item(request_t r);
		while (idle_on && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, r.idx, r.label, r.chain, r.zone, r.points};
		s_axis_tuser <= r.op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(apply_request(r));
		case (r.op)
			OP_INSERT: n_insert++;
			OP_QUERY:  n_query++;
			OP_READ:   n_read++;
			default:   n_other++;
		endcase
	endtask

	task automatic send_fields(logic [1:0] op, logic [POINTS_W-1:0] points,
			logic [LABEL_W-1:0] label, logic signed [INDEX_W-1:0] idx);
		request_t r;
		r.op = op;
		r.points = points;
		r.zone = 16'($urandom_range(16'hFFFF));
		r.chain = 16'($urandom_range(16'hFFFF));
		r.label = label;
		r.idx = idx;
		send_item(r);
	endtask

	task automatic test_empty_table();
		send_fields(OP_READ, 31'd7, 64'h0, 8'sd0);
		send_fields(OP_READ, 31'd7, 64'h0, -8'sd1);
		send_fields(OP_READ, 31'd7, 64'h0, 8'sd64);
		send_fields(OP_UNUSED, 31'd9, 64'h1, 8'sd0);
		send_fields(OP_INSERT, 31'd0, 64'h41, 8'sd0);
		send_fields(OP_QUERY, 31'd0, 64'h41, 8'sd0);
		send_fields(OP_QUERY, 31'd5, 64'h41, 8'sd0);
	endtask

	task automatic test_insert_order();
		request_t r;
		r.op = OP_INSERT;
		r.points = 31'h7FFF_FFFF;
		r.zone = 16'hFFFF;
		r.chain = 16'hFFFF;
		r.label = 64'hFFFF_FFFF_FFFF_FFFF;
		r.idx = -8'sd1;
		send_item(r);
		r.points = 31'd1;
		r.zone = 16'h0000;
		r.chain = 16'h0000;
		r.label = 64'h0;
		r.idx = 8'sd0;
		send_item(r);
		// empty first byte, rest ignored
		send_fields(OP_INSERT, 31'd500, 64'hFFFF_FFFF_FFFF_FF00, 8'sd0);
		// zero inside the name clears the bytes after it
		send_fields(OP_INSERT, 31'd500, 64'hFFFF_FF00_6463_6261, 8'sd0);
		send_fields(OP_INSERT, 31'h7FFF_FFFF, 64'h0000_0000_0000_005A, 8'sd0);
		send_fields(OP_QUERY, 31'd1, 64'h0, 8'sd0);
		send_fields(OP_QUERY, 31'd500, 64'h0, 8'sd0);
	endtask

	task automatic test_read_clamp();
		send_fields(OP_READ, 31'd0, 64'h0, -8'sd128);
		send_fields(OP_READ, 31'd0, 64'h0, -8'sd1);
		send_fields(OP_READ, 31'd0, 64'h0, 8'sd0);
		send_fields(OP_READ, 31'd0, 64'h0, 8'sd2);
		send_fields(OP_READ, 31'd0, 64'h0, 8'sd64);
		send_fields(OP_READ, 31'd0, 64'h0, 8'sd127);
	endtask

	task automatic test_full_table();
		logic [POINTS_W-1:0] last;
		while (filled < DEPTH)
			send_fields(OP_INSERT, 31'($urandom_range(1000, 2)), {$urandom(), $urandom()},
				8'sd0);
		last = score_table[DEPTH-1].points;
		send_fields(OP_INSERT, last, 64'h4C41_5354, 8'sd0);
		send_fields(OP_QUERY, last, 64'h0, 8'sd0);
		send_fields(OP_INSERT, 31'd0, 64'h0, 8'sd0);
		send_fields(OP_INSERT, last + 31'd1, 64'h4E45_5754, 8'sd0);
		send_fields(OP_READ, 31'd0, 64'h0, 8'sd15);
		send_fields(OP_READ, 31'd0, 64'h0, 8'sd16);
	endtask

	task automatic test_output_backpressure();
		hold_left = 300;
		repeat (12)
			send_item(random_request());
	endtask

	task automatic test_random_mix(int n_items);
		repeat (n_items)
			send_item(random_request());
	endtask

	task automatic test_back_to_back(int n_items);
		idle_on = 1'b0;
		stall_on = 1'b0;
		repeat (n_items)
			send_item(random_request());
		idle_on = 1'b1;
		stall_on = 1'b1;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_on) begin
			m_axis_tready <= ($urandom_range(99) >= 38);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		score_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no request pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (want.inserted)
					n_stored++;
				check_field("rank", 64'($unsigned(want.rank)), 64'(m_axis_tdata[6:0]));
				check_field("inserted", 64'(want.inserted), 64'(m_axis_tuser[0]));
				check_field("entry_count", 64'(want.count), 64'(m_axis_tdata[13:7]));
				check_field("entry_valid", 64'(want.valid), 64'(m_axis_tuser[1]));
				check_field("entry_points", 64'(want.entry.points), 64'(m_axis_tdata[44:14]));
				check_field("entry_zone", 64'(want.entry.zone), 64'(m_axis_tdata[60:45]));
				check_field("entry_chain", 64'(want.entry.chain), 64'(m_axis_tdata[76:61]));
				check_field("entry_label", want.entry.label, m_axis_tdata[140:77]);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("sorted_top_n_table verification failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_insert_order();
		test_read_clamp();
		test_full_table();
		test_output_backpressure();
		test_random_mix(225);
		test_back_to_back(150);
		test_random_mix(225);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results still pending at the end", pending_results.size());
			errors++;
		end
		$display("checked %0d results: %0d inserts (%0d stored), %0d rank queries, %0d reads,",
			results_checked, n_insert, n_stored, n_query, n_read);
		$display("%0d unused op items, final fill %0d of %0d, %0d mismatches",
			n_other, filled, DEPTH, errors);
		if (errors == 0)
			$display("sorted_top_n_table verification clean");
		else
			$display("sorted_top_n_table verification failed");
		$finish;
	end

endmodule

`default_nettype wire
